>>> hw/rtl/ptm_pkg.sv
// Shared types and constants for the 64-bit Miller-Rabin primality tester.
// No dependencies; used by ptm_mulmod and primality_test_64.
`default_nettype none
package ptm_pkg;
    typedef logic [63:0] t_word;

    localparam int NUM_BASES = 7;

    localparam t_word BASES [NUM_BASES] = '{
        64'd2, 64'd325, 64'd9375, 64'd28178,
        64'd450775, 64'd9780504, 64'd1795265022
    };
endpackage
`default_nettype wire

>>> hw/rtl/primality_test_64.sv
// Deterministic Miller-Rabin test of a 64-bit number with seven fixed bases.
// A number below 3 or even gives its result in the cycle after it is taken; otherwise
// the result waits on the shared bit-serial multiplier, with up to ~130 modular
// products per base plus squarings.
// One item at a time; the next item can be taken in the cycle after the result is taken.
// Synchronous active-low reset returns the sequencer to idle and drops any pending result.
`default_nettype none
module primality_test_64 (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_stall,
    input  ptm_pkg::t_word  i_number,
    output logic            o_valid,
    input  wire             i_stall,
    output logic            o_is_prime
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FACT  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_BASE  = 4'd3;
    localparam logic [3:0] S_PSTEP = 4'd4;
    localparam logic [3:0] S_PMUL1 = 4'd5;
    localparam logic [3:0] S_PMUL2 = 4'd6;
    localparam logic [3:0] S_CHK   = 4'd7;
    localparam logic [3:0] S_SQ    = 4'd8;
    localparam logic [3:0] S_NEXT  = 4'd9;

    logic [3:0]     r_state;
    logic [3:0]     r_ret;
    logic [2:0]     r_k;
    logic [5:0]     r_s;
    logic [5:0]     r_i;
    ptm_pkg::t_word r_n;
    ptm_pkg::t_word r_d;
    ptm_pkg::t_word r_e;
    ptm_pkg::t_word r_b;
    ptm_pkg::t_word r_x;
    logic           r_ov;
    logic           r_res;

    logic           w_start;
    ptm_pkg::t_word w_ma;
    ptm_pkg::t_word w_mq;
    logic           w_done;
    ptm_pkg::t_word w_prod;
    logic           w_acc_in;
    ptm_pkg::t_word w_nm1;

    assign w_acc_in = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE) || r_ov;
    assign o_valid  = r_ov;
    assign o_is_prime = r_res;
    assign w_nm1 = r_n - 64'd1;

    // operand select for the shared multiplier
    always_comb begin
        w_start = 1'b0;
        w_ma = r_x;
        w_mq = r_x;
        unique case (r_state)
            S_FACT: begin
                w_start = r_d[0];
                w_ma = 64'd1;
                w_mq = ptm_pkg::BASES[r_k];
            end
            S_NEXT: begin
                w_start = (r_k != 3'(ptm_pkg::NUM_BASES - 1));
                w_ma = 64'd1;
                w_mq = ptm_pkg::BASES[3'(r_k + 3'd1)];
            end
            S_PSTEP: begin
                w_start = (r_e != 64'd0);
                w_ma = r_e[0] ? r_x : r_b;
                w_mq = r_b;
            end
            S_PMUL1: begin
                w_start = 1'b1;
                w_ma = r_b;
                w_mq = r_b;
            end
            S_CHK: begin
                w_start = !((r_x == 64'd0) || (r_x == 64'd1) || (r_x == w_nm1));
            end
            S_SQ: begin
                w_start = !((w_prod == w_nm1) || (w_prod == 64'd1)
                            || ({1'b0, r_i} + 7'd1 == {1'b0, r_s}));
                w_ma = w_prod;
                w_mq = w_prod;
            end
            default: begin
                w_start = 1'b0;
            end
        endcase
    end

    ptm_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (w_ma),
        .i_q     (w_mq),
        .i_m     (r_n),
        .o_done  (w_done),
        .o_prod  (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_ret   <= S_IDLE;
        end else begin
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc_in) begin
                        if (i_number < 64'd3 || !i_number[0]) begin
                            r_ov  <= 1'b1;
                            r_res <= (i_number == 64'd2);
                        end else begin
                            r_state <= S_FACT;
                        end
                    end
                end
                S_FACT: begin
                    if (r_d[0]) begin
                        r_state <= S_MUL;
                        r_ret   <= S_BASE;
                    end
                end
                S_MUL: begin
                    if (w_done) begin
                        r_state <= r_ret;
                    end
                end
                S_BASE: begin
                    r_state <= S_PSTEP;
                end
                S_PSTEP: begin
                    if (r_e == 64'd0) begin
                        r_state <= S_CHK;
                    end else begin
                        r_state <= S_MUL;
                        r_ret   <= r_e[0] ? S_PMUL1 : S_PMUL2;
                    end
                end
                S_PMUL1: begin
                    r_state <= S_MUL;
                    r_ret   <= S_PMUL2;
                end
                S_PMUL2: begin
                    r_state <= S_PSTEP;
                end
                S_CHK: begin
                    if (w_start) begin
                        r_state <= S_MUL;
                        r_ret   <= S_SQ;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_SQ: begin
                    if (w_prod == w_nm1 && ({1'b0, r_i} + 7'd1 != {1'b0, r_s})) begin
                        r_state <= S_NEXT;
                    end else if (!w_start) begin
                        // hit 1, or ran out of squarings: composite
                        r_state <= S_IDLE;
                        r_ov    <= 1'b1;
                        r_res   <= 1'b0;
                    end else begin
                        r_state <= S_MUL;
                        r_ret   <= S_SQ;
                    end
                end
                S_NEXT: begin
                    if (r_k == 3'(ptm_pkg::NUM_BASES - 1)) begin
                        r_state <= S_IDLE;
                        r_ov    <= 1'b1;
                        r_res   <= 1'b1;
                    end else begin
                        r_state <= S_MUL;
                        r_ret   <= S_BASE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_n <= i_number;
                r_d <= i_number - 64'd1;
                r_s <= '0;
                r_k <= '0;
            end
            S_FACT: begin
                if (!r_d[0]) begin
                    r_d <= {1'b0, r_d[63:1]};
                    r_s <= r_s + 6'd1;
                end
            end
            S_BASE: begin
                r_b <= w_prod;
                r_x <= 64'd1;
                r_e <= r_d;
            end
            S_PMUL1: begin
                r_x <= w_prod;
            end
            S_PMUL2: begin
                r_b <= w_prod;
                r_e <= {1'b0, r_e[63:1]};
            end
            S_CHK: begin
                r_i <= '0;
            end
            S_SQ: begin
                r_x <= w_prod;
                r_i <= r_i + 6'd1;
            end
            S_NEXT: begin
                r_k <= r_k + 3'd1;
            end
            default: begin
            end
        endcase
    end

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("input taken while busy");

    a_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_MUL))
        else $error("product finished outside multiply wait");

    a_base_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_k < 3'(ptm_pkg::NUM_BASES)))
        else $error("base index out of range");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> r_ov)
        else $error("pending result dropped");
endmodule
`default_nettype wire

>>> hw/rtl/ptm_mulmod.sv
// Bit-serial modular multiplier: (a * q) mod m, one bit of q per cycle.
// Depends on ptm_pkg. Requires a < m; o_done flags when the product is ready.
`default_nettype none
module ptm_mulmod (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  ptm_pkg::t_word     i_a,
    input  ptm_pkg::t_word     i_q,
    input  ptm_pkg::t_word     i_m,
    output logic               o_done,
    output ptm_pkg::t_word     o_prod
);
    logic           r_busy;
    logic           r_done;
    logic [5:0]     r_cnt;
    ptm_pkg::t_word r_acc;
    ptm_pkg::t_word r_q;
    ptm_pkg::t_word r_a;
    ptm_pkg::t_word n_acc;
    logic [64:0]    w_dbl;
    logic [64:0]    w_dbl_red;
    logic [64:0]    w_sum;
    logic [64:0]    w_mext;

    // double, reduce, then conditionally add a and reduce
    always_comb begin
        w_mext = {1'b0, i_m};
        w_dbl = {r_acc, 1'b0};
        w_dbl_red = (w_dbl >= w_mext) ? (w_dbl - w_mext) : w_dbl;
        w_sum = w_dbl_red + {1'b0, r_a};
        if (w_sum >= w_mext) begin
            w_sum = w_sum - w_mext;
        end
        n_acc = r_q[63] ? w_sum[63:0] : w_dbl_red[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_q   <= i_q;
            r_a   <= i_a;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_q   <= {r_q[62:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule
`default_nettype wire
